// ===== rtl/fhc_pkg.sv =====
package fhc_pkg;

    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [3:0]  HEADER_BYTES = 4'd10;
    localparam logic [3:0]  CRC_START    = 4'd6;
    localparam logic [3:0]  CRC_HI_POS   = 4'd4;
    localparam logic [3:0]  CRC_LO_POS   = 4'd5;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_CRC_FAIL = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key_length;
        logic [15:0] computed_crc;
    } fhc_result_t;

    typedef struct packed {
        logic        valid;
        fhc_result_t result;
    } fhc_result_beat_t;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/fhc_in_if.sv =====
interface fhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/fhc_out_if.sv =====
interface fhc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] key_length;
    logic [15:0] computed_crc;

    modport source (output valid, output status, output key_length, output computed_crc,
                    input ready);
    modport sink   (input valid, input status, input key_length, input computed_crc,
                    output ready);
endinterface

// ===== rtl/frame_header_crc_checker.sv =====
// frame header crc checker
// frames: one byte per beat, last_byte marks the final byte of a frame.
// bytes 4..5 hold the stored crc, bytes 6..9 the key length (both big-endian);
// crc-16/ccitt-false runs over every byte from offset 6 to the end.
// results: one beat per frame, issued for the last byte only, carrying
// status (ok, short frame, crc mismatch), key_length (zero unless ok) and
// the computed crc.
// the result is registered: it appears in the cycle after the last byte is accepted.
// throughput: one byte per cycle while frames.ready is high; the crc update
// and header capture for a byte are combinational, ahead of the result register.
// a single result register sits on the output: frames.ready stays high while
// it is empty or being drained, so bytes keep flowing while a result waits
// only if the receiver takes it in the same cycle; while a result is held
// and results.ready is low, frames.ready drops and the byte stream stalls.
// reset clears the position counter, reloads the crc seed and empties the
// result register; after each last byte the checker rearms for a new frame.
module frame_header_crc_checker
    import fhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fhc_in_if.sink    frames,
    fhc_out_if.source results
);

    fhc_result_beat_t beat;
    logic             free;
    logic             accept;

    assign frames.ready = free;
    assign accept       = frames.valid && free;

    fhc_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frames.frame_byte),
        .last_byte  (frames.last_byte),
        .beat       (beat)
    );

    fhc_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .free    (free),
        .results (results)
    );

endmodule

// ===== rtl/fhc_tracker.sv =====
module fhc_tracker
    import fhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       frame_byte,
    input  logic             last_byte,
    output fhc_result_beat_t beat
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] rx_crc_reg;
    logic [15:0] rx_crc_next;
    logic [31:0] key_len_reg;
    logic [31:0] key_len_next;
    logic [1:0]  status;

    always_comb
    begin
        rx_crc_next  = rx_crc_reg;
        key_len_next = key_len_reg;
        crc_next     = crc_reg;
        pos_next     = pos_reg;
        if (pos_reg == CRC_HI_POS || pos_reg == CRC_LO_POS)
        begin
            rx_crc_next = {rx_crc_reg[7:0], frame_byte};
        end
        if (pos_reg >= CRC_START && pos_reg < HEADER_BYTES)
        begin
            key_len_next = {key_len_reg[23:0], frame_byte};
        end
        if (pos_reg >= CRC_START)
        begin
            crc_next = crc_byte(crc_reg, frame_byte);
        end
        if (pos_reg < HEADER_BYTES)
        begin
            pos_next = pos_reg + 4'd1;
        end

        if (pos_next < HEADER_BYTES)
        begin
            status = STATUS_SHORT;
        end
        else if (crc_next != rx_crc_next)
        begin
            status = STATUS_CRC_FAIL;
        end
        else
        begin
            status = STATUS_OK;
        end

        beat.valid               = accept && last_byte;
        beat.result.status       = status;
        beat.result.key_length   = (status == STATUS_OK) ? key_len_next : 32'd0;
        beat.result.computed_crc = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 4'd0;
            crc_reg     <= CRC_SEED;
            rx_crc_reg  <= 16'd0;
            key_len_reg <= 32'd0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg     <= 4'd0;
                crc_reg     <= CRC_SEED;
                rx_crc_reg  <= 16'd0;
                key_len_reg <= 32'd0;
            end
            else
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                rx_crc_reg  <= rx_crc_next;
                key_len_reg <= key_len_next;
            end
        end
    end

endmodule

// ===== rtl/fhc_out_reg.sv =====
module fhc_out_reg
    import fhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fhc_result_beat_t beat,
    output logic             free,
    fhc_out_if.source        results
);

    logic        valid_reg;
    fhc_result_t data_reg;

    assign free                 = !valid_reg || results.ready;
    assign results.valid        = valid_reg;
    assign results.status       = data_reg.status;
    assign results.key_length   = data_reg.key_length;
    assign results.computed_crc = data_reg.computed_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (beat.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.valid)
        begin
            data_reg <= beat.result;
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import fhc_pkg::*;

    localparam int BYTES_PER_PHASE = 440;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 2000;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_SHORT, FRAME_NOISE} frame_kind_e;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        fhc_result_t want;
    } stim_row_t;

    typedef struct {
        logic [3:0]  pos;
        logic [15:0] crc;
        logic [15:0] stored_crc;
        logic [31:0] key;
    } header_state_t;

    // single short frame, the check string frame (correct crc, long), a 9 byte short frame
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{8'hFF, 1'b1, 1'b1, '{STATUS_SHORT, 32'd0, CRC_SEED}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b0, '0},
        '{8'h29, 1'b0, 1'b0, '0},
        '{8'hB1, 1'b0, 1'b0, '0},
        '{8'h31, 1'b0, 1'b0, '0},
        '{8'h32, 1'b0, 1'b0, '0},
        '{8'h33, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h35, 1'b0, 1'b0, '0},
        '{8'h36, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h38, 1'b0, 1'b0, '0},
        '{8'h39, 1'b1, 1'b1, '{STATUS_OK, 32'h3132_3334, 16'h29B1}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fhc_in_if  frames();
    fhc_out_if results();

    frame_header_crc_checker u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames),
        .results (results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    header_state_t hdr;
    fhc_result_t   awaited_frame_results[$];
    logic [7:0]    frame_buf[$];
    int            fail_count = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            hold_requests = 0;
    int            bytes_sent = 0;
    int            quiet_cycles = 0;

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_header();
        hdr.pos        = '0;
        hdr.crc        = CRC_SEED;
        hdr.stored_crc = '0;
        hdr.key        = '0;
    endfunction

    // returns 1 when the byte closes a frame
    function automatic bit track_header(input logic [7:0] b, input logic l,
                                        output fhc_result_t res);
        res = '0;
        if (hdr.pos == CRC_HI_POS || hdr.pos == CRC_LO_POS)
        begin
            hdr.stored_crc = {hdr.stored_crc[7:0], b};
        end
        if (hdr.pos >= CRC_START && hdr.pos < HEADER_BYTES)
        begin
            hdr.key = {hdr.key[23:0], b};
        end
        if (hdr.pos >= CRC_START)
        begin
            hdr.crc = crc_fold(hdr.crc, b);
        end
        if (hdr.pos < HEADER_BYTES)
        begin
            hdr.pos = hdr.pos + 4'd1;
        end
        if (!l)
        begin
            return 1'b0;
        end
        if (hdr.pos < HEADER_BYTES)
        begin
            res.status = STATUS_SHORT;
        end
        else if (hdr.crc != hdr.stored_crc)
        begin
            res.status = STATUS_CRC_FAIL;
        end
        else
        begin
            res.status = STATUS_OK;
        end
        res.key_length   = (res.status == STATUS_OK) ? hdr.key : 32'd0;
        res.computed_crc = hdr.crc;
        clear_header();
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("error at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            flag_error($sformatf("%s expected %0h, got %0h", name, want, got));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            fhc_result_t want;
            if (awaited_frame_results.size() == 0)
            begin
                flag_error("result beat with no frame outstanding");
            end
            else
            begin
                want = awaited_frame_results.pop_front();
                check_field("status", 32'(want.status), 32'(results.status));
                check_field("key_length", want.key_length, results.key_length);
                check_field("computed_crc", 32'(want.computed_crc),
                            32'(results.computed_crc));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frames.valid && frames.ready) || (results.valid && results.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("** frame_header_crc_checker: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left     = 0;
        hold_served   = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l, input bit typed,
                             input fhc_result_t want);
        fhc_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            frames.valid <= 1'b0;
            @(posedge clk);
        end
        frames.valid      <= 1'b1;
        frames.frame_byte <= b;
        frames.last_byte  <= l;
        do
            @(posedge clk);
        while (frames.ready !== 1'b1);
        bytes_sent++;
        if (track_header(b, l, res))
        begin
            awaited_frame_results.push_back(typed ? want : res);
        end
    endtask

    task automatic send_frame(input frame_kind_e kind);
        int          len;
        logic [15:0] crc;
        logic [31:0] key;
        frame_buf.delete();
        case (kind)
            FRAME_SHORT: len = $urandom_range(9, 1);
            FRAME_NOISE: len = $urandom_range(40, 1);
            default:     len = ($urandom_range(9) == 0) ? $urandom_range(64, 11)
                                                        : $urandom_range(20, 10);
        endcase
        for (int i = 0; i < len; i++)
        begin
            frame_buf.push_back(8'($urandom_range(255)));
        end
        if (kind == FRAME_GOOD || kind == FRAME_BAD_CRC)
        begin
            case ($urandom_range(3))
                0:       key = 32'd0;
                1:       key = '1;
                default: key = $urandom;
            endcase
            frame_buf[6] = key[31:24];
            frame_buf[7] = key[23:16];
            frame_buf[8] = key[15:8];
            frame_buf[9] = key[7:0];
            crc = CRC_SEED;
            for (int i = 6; i < len; i++)
            begin
                crc = crc_fold(crc, frame_buf[i]);
            end
            if (kind == FRAME_BAD_CRC)
            begin
                crc = crc ^ 16'($urandom_range(65535, 1));
            end
            frame_buf[4] = crc[15:8];
            frame_buf[5] = crc[7:0];
        end
        for (int i = 0; i < len; i++)
        begin
            send_beat(frame_buf[i], i == len - 1, 1'b0, '0);
        end
    endtask

    function automatic frame_kind_e pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return FRAME_GOOD;
        end
        else if (r < 75)
        begin
            return FRAME_BAD_CRC;
        end
        else if (r < 90)
        begin
            return FRAME_SHORT;
        end
        return FRAME_NOISE;
    endfunction

    task automatic wait_for_results();
        frames.valid <= 1'b0;
        while (awaited_frame_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int target;
        frames.valid      = 1'b0;
        frames.frame_byte = 8'h00;
        frames.last_byte  = 1'b0;
        clear_header();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 74; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 74; end
                default: begin idle_pct = 36; stall_pct <= 36; end
            endcase
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
            begin
                send_frame(pick_kind());
            end
            if (phase == 0)
            begin
                // receiver holds off while one-byte frames keep coming
                hold_requests <= hold_requests + 1;
                repeat (12)
                begin
                    send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
                end
            end
            wait_for_results();
        end

        if (fail_count == 0)
        begin
            $display("** frame_header_crc_checker: PASSED **");
        end
        else
        begin
            $display("** frame_header_crc_checker: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fhc_pkg.sv
rtl/fhc_in_if.sv
rtl/fhc_out_if.sv
rtl/fhc_tracker.sv
rtl/fhc_out_reg.sv
rtl/frame_header_crc_checker.sv
sim/testbench.sv
